@@ hw/rtl/sparse_row_bitmap_tile_codec_macros.svh @@
// Assertion macros shared by the tile codec RTL.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef SPARSE_ROW_BITMAP_TILE_CODEC_MACROS_SVH
`define SPARSE_ROW_BITMAP_TILE_CODEC_MACROS_SVH

// Same-cycle implication, checked outside reset
`define SRBTC_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("tile codec check failed");

// Next-cycle implication, checked outside reset
`define SRBTC_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("tile codec check failed");

`endif

@@ hw/rtl/srbtc_pkg.sv @@
// Shared types and constants for the sparse row bitmap tile codec.
// No dependencies; imported by the codec top level.
package srbtc_pkg;

   localparam int TILE_ROWS_DEF     = 256;
   localparam int WORDS_PER_ROW_DEF = 4;
   localparam int WORD_W            = 64;

   // Item function codes carried on req_tuser
   typedef enum logic [1:0] {
      FN_SET   = 2'd0,
      FN_CLR   = 2'd1,
      FN_READ  = 2'd2,
      FN_WRITE = 2'd3
   } func_type;

   // Sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_PIX,
      ST_RDAT,
      ST_WDAT,
      ST_WFIN
   } state_type;

endpackage

@@ hw/rtl/srbtc_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies; used for the pixel and word-occupancy stores.
module srbtc_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 1024,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hw/rtl/sparse_row_bitmap_tile_codec.sv @@
// Sparse row bitmap tile codec: a TILE_ROWS x (64*WORDS_PER_ROW) bit tile with a
// stream encoder/decoder. Uses srbtc_pkg, srbtc_ram and the assertion macro header.
//
// req_tready is low from each accepted beat until the sequencer is back in idle. Header
// reads, out-of-range pixels and all header write words but the final one go through
// accept, then decode and result. Set, clear, row-word reads and writes and the final
// header write word add a state after decode for the registered read of the pixel RAM
// and the per-row word-occupancy RAM before the write back, or the drop of unmarked rows.
// A pending result stalled on rsp_tready holds the sequencer in its current state.
// Row flags live in flip-flops, so the next non-empty or marked row is found by a
// combinational priority search, and no clearing pass is needed after reset: a row
// whose flag is clear reads as zero. A result may wait on rsp_tready while the next
// req beat is accepted.
`include "sparse_row_bitmap_tile_codec_macros.svh"

module sparse_row_bitmap_tile_codec
   import srbtc_pkg::*;
#(
   parameter int TILE_ROWS     = TILE_ROWS_DEF,
   parameter int WORDS_PER_ROW = WORDS_PER_ROW_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [79:0] req_tdata,   // col[7:0], row[15:8], data_word[79:16]
   input  logic [1:0]  req_tuser,   // func[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // out_word[63:0]
   output logic        rsp_tlast
);

   localparam int HW    = (TILE_ROWS + 63) / 64;
   localparam int HIW   = (HW > 1) ? $clog2(HW) : 1;
   localparam int RW    = $clog2(TILE_ROWS);
   localparam int WW    = (WORDS_PER_ROW > 1) ? $clog2(WORDS_PER_ROW) : 1;
   localparam int PDEP  = TILE_ROWS * (2 ** WW);
   localparam int PAW   = RW + WW;

   state_type state_ff, state_in;

   // Registered item
   func_type          item_func_ff;
   logic [7:0]        item_col_ff, item_row_ff;
   logic [WORD_W-1:0] item_data_ff;

   // Row flags and write header latch
   logic [TILE_ROWS-1:0] occ_ff, occ_in;
   logic [WORD_W-1:0]    hdr_ff [HW];
   logic [WORD_W-1:0]    hdr_in [HW];

   // Read and write stream pointers
   logic           rd_hdr_ff, rd_hdr_in, wr_hdr_ff, wr_hdr_in;
   logic [HIW-1:0] rd_idx_ff, rd_idx_in, wr_idx_ff, wr_idx_in;
   logic [RW-1:0]  rd_row_ff, rd_row_in, wr_row_ff, wr_row_in;
   logic [WW-1:0]  rd_word_ff, rd_word_in, wr_word_ff, wr_word_in;

   // Result register
   logic              rsp_valid_ff, rsp_valid_in;
   logic [WORD_W-1:0] rsp_word_ff, rsp_word_in;
   logic              rsp_last_ff, rsp_last_in;

   // RAM ports
   logic                     pix_we, pix_re, msk_we, msk_re;
   logic [PAW-1:0]           pix_waddr, pix_raddr;
   logic [RW-1:0]            msk_waddr, msk_raddr;
   logic [WORD_W-1:0]        pix_wdata, pix_rdata;
   logic [WORDS_PER_ROW-1:0] msk_wdata, msk_rdata;

   logic req_fire, out_free, rsp_load;

   srbtc_ram #(.WIDTH(WORD_W), .DEPTH(PDEP)) u_pix_ram (
      .clock   (clock),
      .wr_en   (pix_we),
      .wr_addr (pix_waddr),
      .wr_data (pix_wdata),
      .rd_en   (pix_re),
      .rd_addr (pix_raddr),
      .rd_data (pix_rdata)
   );

   srbtc_ram #(.WIDTH(WORDS_PER_ROW), .DEPTH(TILE_ROWS)) u_msk_ram (
      .clock   (clock),
      .wr_en   (msk_we),
      .wr_addr (msk_waddr),
      .wr_data (msk_wdata),
      .rd_en   (msk_re),
      .rd_addr (msk_raddr),
      .rd_data (msk_rdata)
   );

   assign req_fire   = req_tvalid && req_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_word_ff;
   assign rsp_tlast  = rsp_last_ff;

   // Item decode
   logic [1:0]        pix_w;
   logic              pix_in_range, rd_last_hdr, wr_last_hdr;
   logic [WORD_W-1:0] pix_bit;
   assign pix_w        = item_col_ff[7:6];
   assign pix_in_range = ({1'b0, item_row_ff} < 9'(TILE_ROWS)) &&
                         ({1'b0, pix_w} < 3'(WORDS_PER_ROW));
   assign pix_bit      = WORD_W'(1) << (6'd63 - item_col_ff[5:0]);
   assign rd_last_hdr  = (32'(rd_idx_ff) == HW - 1);
   assign wr_last_hdr  = (32'(wr_idx_ff) == HW - 1);

   // Header views of the row flags and of the marked rows
   logic [WORD_W-1:0]    occ_words [HW];
   logic [TILE_ROWS-1:0] marked;
   always_comb begin
      for (int h = 0; h < HW; h++) begin
         occ_words[h] = '0;
      end
      for (int r = 0; r < TILE_ROWS; r++) begin
         occ_words[r / 64][63 - (r % 64)] = occ_ff[r];
         marked[r] = hdr_ff[r / 64][63 - (r % 64)];
      end
   end

   // Next non-empty row for reads, next marked row for writes
   logic [TILE_ROWS-1:0] rd_cand, wr_cand;
   logic                 rd_found, wr_found;
   logic [RW-1:0]        rd_next, wr_next;
   always_comb begin
      rd_found = 1'b0;
      wr_found = 1'b0;
      rd_next  = '0;
      wr_next  = '0;
      for (int r = 0; r < TILE_ROWS; r++) begin
         rd_cand[r] = occ_ff[r] && (rd_hdr_ff || (RW'(r) > rd_row_ff));
         wr_cand[r] = marked[r] && (wr_hdr_ff || (RW'(r) > wr_row_ff));
      end
      for (int r = TILE_ROWS - 1; r >= 0; r--) begin
         if (rd_cand[r]) begin
            rd_found = 1'b1;
            rd_next  = RW'(r);
         end
         if (wr_cand[r]) begin
            wr_found = 1'b1;
            wr_next  = RW'(r);
         end
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            if (out_free) begin
               unique case (item_func_ff)
                  FN_SET, FN_CLR: state_in = pix_in_range ? ST_PIX : ST_IDLE;
                  FN_READ:        state_in = rd_hdr_ff ? ST_IDLE : ST_RDAT;
                  FN_WRITE: begin
                     if (!wr_hdr_ff)       state_in = ST_WDAT;
                     else if (wr_last_hdr) state_in = ST_WFIN;
                     else                  state_in = ST_IDLE;
                  end
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_PIX, ST_RDAT, ST_WDAT, ST_WFIN: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Datapath and outputs
   logic [WORD_W-1:0]        old_word, new_word;
   logic [WORDS_PER_ROW-1:0] old_mask, new_mask;
   always_comb begin
      occ_in     = occ_ff;
      hdr_in     = hdr_ff;
      rd_hdr_in  = rd_hdr_ff;
      rd_idx_in  = rd_idx_ff;
      rd_row_in  = rd_row_ff;
      rd_word_in = rd_word_ff;
      wr_hdr_in  = wr_hdr_ff;
      wr_idx_in  = wr_idx_ff;
      wr_row_in  = wr_row_ff;
      wr_word_in = wr_word_ff;
      rsp_load   = 1'b0;
      rsp_word_in = rsp_word_ff;
      rsp_last_in = rsp_last_ff;
      pix_we     = 1'b0;
      msk_we     = 1'b0;
      pix_re     = 1'b0;
      msk_re     = 1'b0;
      pix_raddr  = {item_row_ff[RW-1:0], pix_w[WW-1:0]};
      msk_raddr  = item_row_ff[RW-1:0];
      pix_waddr  = pix_raddr;
      msk_waddr  = msk_raddr;
      pix_wdata  = '0;
      msk_wdata  = '0;
      old_mask   = occ_ff[msk_raddr] ? msk_rdata : '0;
      old_word   = '0;
      new_word   = '0;
      new_mask   = old_mask;

      unique case (state_ff)
         ST_EXEC: begin
            // Start RAM reads for the row that this beat touches
            pix_re = 1'b1;
            msk_re = 1'b1;
            if (item_func_ff == FN_READ) begin
               pix_raddr = {rd_row_ff, rd_word_ff};
               msk_raddr = rd_row_ff;
            end else if (item_func_ff == FN_WRITE) begin
               msk_raddr = wr_row_ff;
            end
            if (out_free) begin
               case (item_func_ff)
                  FN_SET, FN_CLR: begin
                     rd_hdr_in = 1'b1;
                     rd_idx_in = '0;
                     if (!pix_in_range) begin
                        rsp_load    = 1'b1;
                        rsp_word_in = '0;
                        rsp_last_in = 1'b0;
                     end
                  end
                  FN_READ: begin
                     if (rd_hdr_ff) begin
                        rsp_load    = 1'b1;
                        rsp_word_in = occ_words[rd_idx_ff];
                        rsp_last_in = rd_last_hdr && !rd_found;
                        if (!rd_last_hdr) begin
                           rd_idx_in = rd_idx_ff + 1'b1;
                        end else if (rd_found) begin
                           rd_hdr_in  = 1'b0;
                           rd_row_in  = rd_next;
                           rd_word_in = '0;
                        end else begin
                           rd_idx_in = '0;
                        end
                     end
                  end
                  FN_WRITE: begin
                     rd_hdr_in = 1'b1;
                     rd_idx_in = '0;
                     if (wr_hdr_ff) begin
                        hdr_in[wr_idx_ff] = item_data_ff;
                        if (!wr_last_hdr) begin
                           rsp_load    = 1'b1;
                           rsp_word_in = '0;
                           rsp_last_in = 1'b0;
                           wr_idx_in   = wr_idx_ff + 1'b1;
                        end
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_PIX: begin
            // Read-modify-write of one pixel word and its occupancy bit
            old_word = old_mask[pix_w[WW-1:0]] ? pix_rdata : '0;
            new_word = (item_func_ff == FN_SET) ? (old_word | pix_bit)
                                                : (old_word & ~pix_bit);
            new_mask[pix_w[WW-1:0]] = (new_word != '0);
            if (out_free) begin
               pix_we      = 1'b1;
               msk_we      = 1'b1;
               pix_wdata   = new_word;
               msk_wdata   = new_mask;
               occ_in[msk_waddr] = (new_mask != '0);
               rsp_load    = 1'b1;
               rsp_word_in = '0;
               rsp_last_in = 1'b0;
            end
         end
         ST_RDAT: begin
            msk_raddr = rd_row_ff;
            old_mask  = occ_ff[rd_row_ff] ? msk_rdata : '0;
            if (out_free) begin
               rsp_load    = 1'b1;
               rsp_word_in = old_mask[rd_word_ff] ? pix_rdata : '0;
               rsp_last_in = 1'b0;
               if (32'(rd_word_ff) != WORDS_PER_ROW - 1) begin
                  rd_word_in = rd_word_ff + 1'b1;
               end else if (rd_found) begin
                  rd_row_in  = rd_next;
                  rd_word_in = '0;
               end else begin
                  rsp_last_in = 1'b1;
                  rd_hdr_in   = 1'b1;
                  rd_idx_in   = '0;
               end
            end
         end
         ST_WDAT: begin
            // Store one row word of the incoming stream
            msk_raddr = wr_row_ff;
            msk_waddr = wr_row_ff;
            pix_waddr = {wr_row_ff, wr_word_ff};
            old_mask  = occ_ff[wr_row_ff] ? msk_rdata : '0;
            new_mask  = old_mask;
            new_mask[wr_word_ff] = (item_data_ff != '0);
            if (out_free) begin
               pix_we      = 1'b1;
               msk_we      = 1'b1;
               pix_wdata   = item_data_ff;
               msk_wdata   = new_mask;
               occ_in[wr_row_ff] = (new_mask != '0);
               rsp_load    = 1'b1;
               rsp_word_in = '0;
               rsp_last_in = 1'b0;
               if (32'(wr_word_ff) != WORDS_PER_ROW - 1) begin
                  wr_word_in = wr_word_ff + 1'b1;
               end else if (wr_found) begin
                  wr_row_in  = wr_next;
                  wr_word_in = '0;
               end else begin
                  rsp_last_in = 1'b1;
                  wr_hdr_in   = 1'b1;
                  wr_idx_in   = '0;
               end
            end
         end
         ST_WFIN: begin
            // Header complete: drop unmarked rows, point at the first marked row
            if (out_free) begin
               occ_in      = occ_ff & marked;
               rsp_load    = 1'b1;
               rsp_word_in = '0;
               rsp_last_in = !wr_found;
               if (wr_found) begin
                  wr_hdr_in  = 1'b0;
                  wr_row_in  = wr_next;
                  wr_word_in = '0;
               end else begin
                  wr_idx_in = '0;
               end
            end
         end
         default: ;
      endcase

      rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_tready);
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         occ_ff       <= '0;
         rd_hdr_ff    <= 1'b1;
         rd_idx_ff    <= '0;
         wr_hdr_ff    <= 1'b1;
         wr_idx_ff    <= '0;
         rsp_valid_ff <= 1'b0;
         for (int h = 0; h < HW; h++) begin
            hdr_ff[h] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         occ_ff       <= occ_in;
         rd_hdr_ff    <= rd_hdr_in;
         rd_idx_ff    <= rd_idx_in;
         wr_hdr_ff    <= wr_hdr_in;
         wr_idx_ff    <= wr_idx_in;
         rsp_valid_ff <= rsp_valid_in;
         hdr_ff       <= hdr_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      rd_row_ff   <= rd_row_in;
      rd_word_ff  <= rd_word_in;
      wr_row_ff   <= wr_row_in;
      wr_word_ff  <= wr_word_in;
      rsp_word_ff <= rsp_word_in;
      rsp_last_ff <= rsp_last_in;
      if (req_fire) begin
         item_func_ff <= func_type'(req_tuser);
         item_col_ff  <= req_tdata[7:0];
         item_row_ff  <= req_tdata[15:8];
         item_data_ff <= req_tdata[79:16];
      end
   end

   // Checks
   `SRBTC_ASSERT_NEXT(a_accept_to_exec, req_fire, state_ff == ST_EXEC)
   `SRBTC_ASSERT_NOW(a_load_when_free, rsp_load, out_free)
   `SRBTC_ASSERT_NOW(a_single_ram_write, pix_we, msk_we)
   `SRBTC_ASSERT_NOW(a_rd_idx_range, rd_hdr_ff, 32'(rd_idx_ff) < HW)
   `SRBTC_ASSERT_NOW(a_wr_idx_range, wr_hdr_ff, 32'(wr_idx_ff) < HW)

endmodule

@@ test/sparse_row_bitmap_tile_codec_tb.sv @@
// Self-checking bench for the sparse row bitmap tile codec: pixel set/clear,
// encoded stream reads and writes, checked against an in-bench tile predictor.
// Depends on srbtc_pkg and the codec RTL only.
module sparse_row_bitmap_tile_codec_tb;
   import srbtc_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NROWS   = 256;
   localparam int NWORDS  = 4;
   localparam int HDR     = 4;
   localparam int CYCLE_LIMIT = 400000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [79:0] req_tdata = '0;   // col[7:0], row[15:8], data_word[79:16]
   logic [1:0]  req_tuser = '0;   // func[1:0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;        // out_word[63:0]
   logic        rsp_tlast;

   sparse_row_bitmap_tile_codec u_dut (.*);

   always #6 clock = ~clock;

   // Predicted tile state
   logic [63:0] tile_words [NROWS*NWORDS];
   logic        row_busy   [NROWS];
   logic [63:0] hdr_latch  [HDR];
   int unsigned rd_ptr, wr_ptr;

   typedef struct packed {
      logic [63:0] word;
      logic        last;
   } beat_type;
   beat_type expected_beats [$];

   int  fail_count = 0;
   int  beats_seen = 0;
   int  cycle_count = 0;
   int  send_idle_pct = 0;
   int  stall_pct = 0;
   int  n_sets = 0, n_reads = 0, n_writes = 0;

   function automatic logic [63:0] msb(int n);
      return 64'd1 << (63 - (n % 64));
   endfunction

   function automatic void update_row_flag(int r);
      logic [63:0] acc = '0;
      for (int j = 0; j < NWORDS; j++) acc |= tile_words[r*NWORDS+j];
      row_busy[r] = (acc != 0);
   endfunction

   function automatic int busy_count();
      int n = 0;
      for (int r = 0; r < NROWS; r++) n += row_busy[r];
      return n;
   endfunction

   function automatic int nth_busy(int k);
      int n = 0;
      for (int r = 0; r < NROWS; r++)
         if (row_busy[r]) begin
            if (n == k) return r;
            n++;
         end
      return 0;
   endfunction

   function automatic bit is_marked(int r);
      return (hdr_latch[r/64] & msb(r)) != 0;
   endfunction

   function automatic int marked_count();
      int n = 0;
      for (int r = 0; r < NROWS; r++) n += is_marked(r);
      return n;
   endfunction

   function automatic int nth_marked(int k);
      int n = 0;
      for (int r = 0; r < NROWS; r++)
         if (is_marked(r)) begin
            if (n == k) return r;
            n++;
         end
      return 0;
   endfunction

   // Tile predictor: applies one item and returns the expected response beat
   function automatic beat_type tile_apply(func_type fn, logic [7:0] col, logic [7:0] row,
                                           logic [63:0] data);
      beat_type b;
      int total, p, q, r, m;
      b = '0;
      case (fn)
         FN_SET, FN_CLR: begin
            rd_ptr = 0;
            if (fn == FN_SET) tile_words[row*NWORDS + col/64] |= msb(col);
            else tile_words[row*NWORDS + col/64] &= ~msb(col);
            update_row_flag(row);
         end
         FN_READ: begin
            total = HDR + busy_count() * NWORDS;
            p = rd_ptr;
            if (p >= total) p = 0;
            if (p < HDR) begin
               for (int k = p*64; k < p*64+64; k++)
                  if (row_busy[k]) b.word |= msb(k);
            end else begin
               q = p - HDR;
               r = nth_busy(q / NWORDS);
               b.word = tile_words[r*NWORDS + q % NWORDS];
            end
            if (p + 1 >= total) begin
               b.last = 1'b1;
               rd_ptr = 0;
            end else rd_ptr = p + 1;
         end
         default: begin
            p = wr_ptr;
            rd_ptr = 0;
            if (p < HDR) begin
               hdr_latch[p] = data;
               wr_ptr = p + 1;
               if (p + 1 == HDR) begin
                  for (int k = 0; k < NROWS; k++)
                     if (!is_marked(k)) begin
                        for (int j = 0; j < NWORDS; j++) tile_words[k*NWORDS+j] = '0;
                        row_busy[k] = 1'b0;
                     end
                  if (marked_count() == 0) begin
                     b.last = 1'b1;
                     wr_ptr = 0;
                  end
               end
            end else begin
               m = marked_count();
               q = p - HDR;
               if (m == 0 || q >= m * NWORDS) wr_ptr = 0;
               else begin
                  r = nth_marked(q / NWORDS);
                  tile_words[r*NWORDS + q % NWORDS] = data;
                  update_row_flag(r);
                  if (q + 1 == m * NWORDS) begin
                     b.last = 1'b1;
                     wr_ptr = 0;
                  end else wr_ptr = p + 1;
               end
            end
         end
      endcase
      return b;
   endfunction

   // Send one beat, with random idle gaps ahead of it; valid drops only while idle
   task automatic send_item(func_type fn, logic [7:0] col, logic [7:0] row,
                            logic [63:0] data);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= fn;
      req_tdata  <= {data, row, col};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      expected_beats.push_back(tile_apply(fn, col, row, data));
      case (fn)
         FN_SET, FN_CLR: n_sets++;
         FN_READ: n_reads++;
         default: n_writes++;
      endcase
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (expected_beats.size() != 0) @(posedge clock);
   endtask

   task automatic read_stream();
      do begin
         send_item(FN_READ, 8'd0, 8'd0, 64'd0);
      end while (rd_ptr != 0);
   endtask

   // Write a full stream with the given header and random row content, or all-zero rows
   task automatic write_stream(logic [63:0] h0, logic [63:0] h1, logic [63:0] h2,
                               logic [63:0] h3, bit zero_rows);
      int m;
      logic [63:0] d;
      send_item(FN_WRITE, 8'd0, 8'd0, h0);
      send_item(FN_WRITE, 8'd0, 8'd0, h1);
      send_item(FN_WRITE, 8'd0, 8'd0, h2);
      send_item(FN_WRITE, 8'd0, 8'd0, h3);
      m = marked_count();
      for (int i = 0; i < m * NWORDS; i++) begin
         d = zero_rows ? 64'd0 : {$urandom, $urandom};
         if (!zero_rows && $urandom_range(3) == 0) d = 64'd0;
         send_item(FN_WRITE, 8'd0, 8'd0, d);
      end
   endtask

   function automatic logic [63:0] sparse_hdr();
      logic [63:0] h = '0;
      int n = $urandom_range(3);
      for (int i = 0; i < n; i++) h |= msb($urandom_range(63));
      return $urandom_range(5) == 0 ? {$urandom, $urandom} & {$urandom, $urandom} : h;
   endfunction

   // Result checker
   always @(posedge clock) begin
      beat_type e;
      if (!reset && rsp_tvalid && rsp_tready) begin
         beats_seen++;
         if (expected_beats.size() == 0) begin
            $error("unexpected response beat word=%h last=%b", rsp_tdata, rsp_tlast);
            fail_count++;
         end else begin
            e = expected_beats.pop_front();
            if (rsp_tdata !== e.word) begin
               $error("out_word: expected %h, got %h", e.word, rsp_tdata);
               fail_count++;
            end
            if (rsp_tlast !== e.last) begin
               $error("last: expected %b, got %b", e.last, rsp_tlast);
               fail_count++;
            end
         end
      end
   end

   // Receiver back-pressure
   always @(posedge clock)
      rsp_tready <= ($urandom_range(99) >= stall_pct);

   // Timeout
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   task automatic test_directed();
      // corner pixels and out of nothing: empty tile stream
      read_stream();
      send_item(FN_SET, 8'd0, 8'd0, 64'd0);
      send_item(FN_SET, 8'd255, 8'd255, 64'd0);
      send_item(FN_SET, 8'd63, 8'd64, 64'hFFFF_FFFF_FFFF_FFFF);
      send_item(FN_SET, 8'd64, 8'd127, 64'd0);
      read_stream();
      send_item(FN_CLR, 8'd63, 8'd64, 64'd0);
      send_item(FN_CLR, 8'd200, 8'd9, 64'd0);
      send_item(FN_READ, 8'd0, 8'd0, 64'd0);
      send_item(FN_READ, 8'd0, 8'd0, 64'd0);
      // write aborts read pointer; header-only write clears the tile
      write_stream(64'd0, 64'd0, 64'd0, 64'd0, 0);
      read_stream();
      // marked row written as all zeros reads back empty
      write_stream(64'h8000_0000_0000_0001, 64'd0, 64'd0, 64'd1, 1);
      read_stream();
      // top two header bits set in the last header word, random row data
      write_stream(64'd0, 64'd0, 64'd0, 64'hC000_0000_0000_0000, 0);
      read_stream();
   endtask

   task automatic test_random(int n_items);
      int sent = 0;
      int prior_count;
      while (sent < n_items) begin
         prior_count = n_sets + n_reads + n_writes;
         case ($urandom_range(9))
            0, 1, 2: send_item(func_type'($urandom_range(1)), 8'($urandom), 8'($urandom),
                               {$urandom, $urandom});
            3, 4: read_stream();
            5: send_item(FN_READ, 8'($urandom), 8'($urandom), {$urandom, $urandom});
            6, 7: write_stream(sparse_hdr(), sparse_hdr(), sparse_hdr(), sparse_hdr(), 0);
            8: send_item(FN_WRITE, 8'($urandom), 8'($urandom), {$urandom, $urandom});
            default: begin
               // partial read stream, broken off by a pixel change
               repeat ($urandom_range(1, 6)) send_item(FN_READ, 8'd0, 8'd0, 64'd0);
               send_item(FN_SET, 8'($urandom), 8'($urandom), 64'd0);
            end
         endcase
         sent += n_sets + n_reads + n_writes - prior_count;
      end
   endtask

   task automatic test_pause();
      send_item(FN_SET, 8'd128, 8'd200, 64'd0);
      wait_drained();
      read_stream();
   endtask

   initial begin
      for (int i = 0; i < NROWS*NWORDS; i++) tile_words[i] = '0;
      for (int i = 0; i < NROWS; i++) row_busy[i] = 1'b0;
      for (int i = 0; i < HDR; i++) hdr_latch[i] = '0;
      rd_ptr = 0;
      wr_ptr = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_random(220);
      send_idle_pct = 76;
      test_random(200);
      test_pause();
      send_idle_pct = 0;
      stall_pct = 76;
      test_random(200);
      send_idle_pct = 33;
      stall_pct = 33;
      test_random(200);
      stall_pct = 0;
      send_idle_pct = 0;

      wait_drained();
      repeat (20) @(posedge clock);
      $display("Covered %0d pixel edits, %0d stream reads, %0d stream writes; %0d beats",
               n_sets, n_reads, n_writes, beats_seen);
      $display("under sender idling and receiver stalls from 0 to 76 percent.");
      if (fail_count == 0 && expected_beats.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
